// ===== hdl/ofrs_pkg.sv =====
package ofrs_pkg;

   // widest frame word address over the supported geometry (16 pages of 32 words)
   localparam int MAX_ADDR_W = 9;
   localparam int INIT_LEN   = 23;

   localparam logic [7:0] CTRL_CMD   = 8'h00;
   localparam logic [7:0] CTRL_DATA  = 8'h40;
   localparam logic [7:0] PAGE_BASE  = 8'hB0;
   localparam logic [7:0] COL_LOW    = 8'h00;
   localparam logic [7:0] COL_HIGH   = 8'h10;
   localparam logic [7:0] INIT_LEN_B = 8'd2;
   localparam logic [7:0] PAGE_LEN_B = 8'd4;

   typedef enum logic [1:0] {
      REQ_TICK    = 2'd0,
      REQ_SET_PIX = 2'd1,
      REQ_CLEAR   = 2'd2,
      REQ_REFRESH = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_INIT   = 2'd1,
      MODE_UPDATE = 2'd2
   } run_mode_type;

   typedef enum logic [2:0] {
      OP_INIT,
      OP_PAGE_CMD,
      OP_PAGE_DATA,
      OP_SET_PIXEL,
      OP_CLEAR,
      OP_ERROR
   } cmd_op_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_RMW,
      B_CLEAR,
      B_DATA
   } back_state_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic               bus_idle;
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
   } req_item_type;

   typedef struct packed {
      logic        xfer_first;
      logic [7:0]  ctrl_byte;
      logic [7:0]  xfer_len;
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        last;
      logic        param_error;
   } rsp_item_type;

   // index: init position, page number, or frame word address depending on op
   typedef struct packed {
      cmd_op_type              op;
      logic [MAX_ADDR_W-1:0]   index;
      logic [5:0]              bit_pos;
   } cmd_type;

   function automatic logic [7:0] init_byte(input logic [4:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = 8'hAE;
         5'd1:    b = 8'hD5;
         5'd2:    b = 8'h80;
         5'd3:    b = 8'hA8;
         5'd4:    b = 8'h3F;
         5'd5:    b = 8'hD3;
         5'd6:    b = 8'h00;
         5'd7:    b = 8'h40;
         5'd8:    b = 8'hA1;
         5'd9:    b = 8'hC8;
         5'd10:   b = 8'hDA;
         5'd11:   b = 8'h12;
         5'd12:   b = 8'h81;
         5'd13:   b = 8'hCF;
         5'd14:   b = 8'hD9;
         5'd15:   b = 8'hF1;
         5'd16:   b = 8'hDB;
         5'd17:   b = 8'h30;
         5'd18:   b = 8'hA4;
         5'd19:   b = 8'hA6;
         5'd20:   b = 8'h8D;
         5'd21:   b = 8'h14;
         5'd22:   b = 8'hAF;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== hdl/oled_framebuffer_refresh_sequencer.sv =====
// Page-mode frame store (WIDTH columns by PAGES pages of eight rows) with a display
// init and refresh sequencer. Requests are decoded at once and queued as commands,
// so req is taken one item per cycle until the four-entry queue fills or a reset
// zeroing pass is running. Commands run one at a time: an init or page command
// emits one word, a set pixel is a read-modify-write on the frame memory (one write
// port, one read port), a page data transfer reads ceil(WIDTH/8) 64-bit words, one
// per cycle while rsp_stall does not hold the output register, and a clear writes
// PAGES*ceil(WIDTH/8) zero words, one per cycle. After reset the same zeroing pass
// runs and req stays stalled until it ends. Results leave through an output
// register; rsp_stall holds the back end first and reaches req only once the
// command queue fills.
module oled_framebuffer_refresh_sequencer #(
   parameter int WIDTH  = 128,
   parameter int PAGES  = 8,
   parameter int HEIGHT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ofrs_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ofrs_pkg::rsp_item_type rsp_data
);
   import ofrs_pkg::*;

   logic    accept;
   logic    cmd_push, q_full, q_valid, q_pop, boot_busy;
   cmd_type cmd_data, q_data;

   assign req_stall = q_full || boot_busy;
   assign accept    = req_valid && !req_stall;

   ofrs_front #(
      .WIDTH  (WIDTH),
      .PAGES  (PAGES),
      .HEIGHT (HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_data)
   );

   ofrs_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   ofrs_back #(
      .WIDTH (WIDTH),
      .PAGES (PAGES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .pop       (q_pop),
      .boot_busy (boot_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/ofrs_front.sv =====
module ofrs_front #(
   parameter int WIDTH  = 128,
   parameter int PAGES  = 8,
   parameter int HEIGHT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  ofrs_pkg::req_item_type req_data,
   output logic                  cmd_push,
   output ofrs_pkg::cmd_type     cmd_data
);
   import ofrs_pkg::*;

   localparam int NW = (WIDTH + 7) / 8;
   localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;

   run_mode_type mode_ff, mode_in;
   logic [4:0]    init_pos_ff, init_pos_in;
   logic [PW-1:0] page_pos_ff, page_pos_in;
   logic          phase_ff, phase_in;
   logic          pending_ff, pending_in;

   logic                  tick;
   logic                  coord_ok;
   logic [3:0]            y_page;
   logic [MAX_ADDR_W-1:0] page_ext, word_ext, pix_addr, base_addr;

   assign tick = accept && (req_data.req_type == REQ_TICK) && req_data.bus_idle;

   assign coord_ok = !req_data.pixel_x[15] && !req_data.pixel_y[15]
                     && (int'(req_data.pixel_x) < WIDTH)
                     && (int'(req_data.pixel_y) < HEIGHT);
   assign y_page   = req_data.pixel_y[6:3];
   assign page_ext = MAX_ADDR_W'(y_page);
   assign word_ext = MAX_ADDR_W'(req_data.pixel_x[7:3]);
   assign pix_addr = MAX_ADDR_W'(page_ext * MAX_ADDR_W'(NW) + word_ext);
   assign base_addr = MAX_ADDR_W'(MAX_ADDR_W'(page_pos_ff) * MAX_ADDR_W'(NW));

   // run mode
   always_comb begin
      mode_in = mode_ff;
      if (tick) begin
         unique case (mode_ff)
            MODE_IDLE:   mode_in = MODE_INIT;
            MODE_INIT:   if (int'(init_pos_ff) >= INIT_LEN) mode_in = MODE_UPDATE;
            MODE_UPDATE: mode_in = MODE_UPDATE;
            default:     mode_in = MODE_IDLE;
         endcase
      end
   end

   always_comb begin
      init_pos_in = init_pos_ff;
      page_pos_in = page_pos_ff;
      phase_in    = phase_ff;
      pending_in  = pending_ff;
      cmd_push    = 1'b0;
      cmd_data    = '{op: OP_CLEAR, index: '0, bit_pos: '0};
      if (accept) begin
         unique case (req_data.req_type)
            REQ_TICK: begin
               if (req_data.bus_idle) begin
                  unique case (mode_ff)
                     MODE_IDLE: init_pos_in = '0;
                     MODE_INIT: begin
                        if (int'(init_pos_ff) < INIT_LEN) begin
                           cmd_push       = 1'b1;
                           cmd_data.op    = OP_INIT;
                           cmd_data.index = MAX_ADDR_W'(init_pos_ff);
                           init_pos_in    = init_pos_ff + 5'd1;
                        end else begin
                           page_pos_in = '0;
                           phase_in    = 1'b0;
                           pending_in  = 1'b1;
                        end
                     end
                     MODE_UPDATE: begin
                        if (pending_ff) begin
                           cmd_push = 1'b1;
                           if (!phase_ff) begin
                              cmd_data.op    = OP_PAGE_CMD;
                              cmd_data.index = MAX_ADDR_W'(page_pos_ff);
                              phase_in       = 1'b1;
                           end else begin
                              cmd_data.op    = OP_PAGE_DATA;
                              cmd_data.index = base_addr;
                              phase_in       = 1'b0;
                              if (page_pos_ff == PW'(PAGES - 1)) begin
                                 page_pos_in = '0;
                                 pending_in  = 1'b0;
                              end else begin
                                 page_pos_in = page_pos_ff + PW'(1);
                              end
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
            REQ_SET_PIX: begin
               if (!coord_ok) begin
                  cmd_push    = 1'b1;
                  cmd_data.op = OP_ERROR;
               end else if (int'(y_page) < PAGES) begin
                  cmd_push         = 1'b1;
                  cmd_data.op      = OP_SET_PIXEL;
                  cmd_data.index   = pix_addr;
                  cmd_data.bit_pos = {req_data.pixel_x[2:0], req_data.pixel_y[2:0]};
               end
            end
            REQ_CLEAR: begin
               cmd_push    = 1'b1;
               cmd_data.op = OP_CLEAR;
            end
            REQ_REFRESH: begin
               pending_in  = 1'b1;
               page_pos_in = '0;
               phase_in    = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         init_pos_ff <= '0;
         page_pos_ff <= '0;
         phase_ff    <= 1'b0;
         pending_ff  <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         init_pos_ff <= init_pos_in;
         page_pos_ff <= page_pos_in;
         phase_ff    <= phase_in;
         pending_ff  <= pending_in;
      end
   end

endmodule

// ===== hdl/ofrs_cmd_fifo.sv =====
module ofrs_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ofrs_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              q_valid,
   output ofrs_pkg::cmd_type q_data
);
   import ofrs_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTRW  = $clog2(DEPTH);

   cmd_type          entry_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTRW:0]    count_ff, count_in;

   assign full    = (count_ff == (PTRW+1)'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTRW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTRW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTRW+1)'(push) - (PTRW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/ofrs_back.sv =====
module ofrs_back #(
   parameter int WIDTH = 128,
   parameter int PAGES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  ofrs_pkg::cmd_type      q_data,
   output logic                   pop,
   output logic                   boot_busy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ofrs_pkg::rsp_item_type rsp_data
);
   import ofrs_pkg::*;

   localparam int NW       = (WIDTH + 7) / 8;
   localparam int DEPTH    = PAGES * NW;
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KW       = $clog2(NW + 1);
   localparam int LAST_CNT = WIDTH - 8 * (NW - 1);
   localparam logic [7:0] DATA_LEN = 8'((WIDTH + 1) % 256);

   logic [63:0] mem [DEPTH];

   back_state_type state_ff, state_in;
   logic          boot_ff, boot_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [5:0]    bit_pos_ff, bit_pos_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [KW-1:0] k_ff, k_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          rd_first_ff, rd_first_in;
   logic          rd_last_ff, rd_last_in;
   logic [63:0]   rd_data_ff;
   logic          out_vld_ff, out_vld_in;
   rsp_item_type  out_ff, out_in;

   logic          out_free, rd_move, issue, data_done, clr_last;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [63:0]   mem_wd;
   logic          load_direct;
   rsp_item_type  direct_word, stream_word;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign rd_move   = rd_vld_ff && out_free;
   assign issue     = (state_ff == B_DATA) && (k_ff < KW'(NW)) && (!rd_vld_ff || rd_move);
   assign data_done = (k_ff == KW'(NW)) && !rd_vld_ff;
   assign clr_last  = (clr_addr_ff == AW'(DEPTH - 1));
   assign boot_busy = boot_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      direct_word = '0;
      case (q_data.op)
         OP_INIT: begin
            direct_word.xfer_first = 1'b1;
            direct_word.ctrl_byte  = CTRL_CMD;
            direct_word.xfer_len   = INIT_LEN_B;
            direct_word.data_word  = {56'd0, init_byte(q_data.index[4:0])};
            direct_word.byte_count = 4'd1;
            direct_word.last       = 1'b1;
         end
         OP_PAGE_CMD: begin
            direct_word.xfer_first = 1'b1;
            direct_word.ctrl_byte  = CTRL_CMD;
            direct_word.xfer_len   = PAGE_LEN_B;
            direct_word.data_word  = {40'd0, COL_HIGH, COL_LOW,
                                      PAGE_BASE | {4'd0, q_data.index[3:0]}};
            direct_word.byte_count = 4'd3;
            direct_word.last       = 1'b1;
         end
         OP_ERROR: direct_word.param_error = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      stream_word            = '0;
      stream_word.xfer_first = rd_first_ff;
      stream_word.ctrl_byte  = CTRL_DATA;
      stream_word.xfer_len   = DATA_LEN;
      stream_word.data_word  = rd_data_ff;
      stream_word.byte_count = rd_last_ff ? 4'(LAST_CNT) : 4'd8;
      stream_word.last       = rd_last_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               unique case (q_data.op) inside
                  OP_SET_PIXEL: state_in = B_RMW;
                  OP_CLEAR:     state_in = B_CLEAR;
                  OP_PAGE_DATA: state_in = B_DATA;
                  default:      state_in = B_IDLE;
               endcase
            end
         end
         B_RMW:   state_in = B_IDLE;
         B_CLEAR: if (clr_last) state_in = B_IDLE;
         B_DATA:  if (data_done) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop         = 1'b0;
      load_direct = 1'b0;
      mem_re      = 1'b0;
      mem_ra      = addr_ff + AW'(k_ff);
      mem_we      = 1'b0;
      mem_wa      = addr_ff;
      mem_wd      = rd_data_ff | (64'd1 << bit_pos_ff);
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               unique case (q_data.op) inside
                  OP_INIT, OP_PAGE_CMD, OP_ERROR: begin
                     pop         = out_free;
                     load_direct = out_free;
                  end
                  OP_SET_PIXEL: begin
                     pop    = 1'b1;
                     mem_re = 1'b1;
                     mem_ra = AW'(q_data.index);
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         B_RMW: mem_we = 1'b1;
         B_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_addr_ff;
            mem_wd = '0;
         end
         B_DATA: mem_re = issue;
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      addr_in     = addr_ff;
      bit_pos_in  = bit_pos_ff;
      clr_addr_in = clr_addr_ff;
      k_in        = k_ff;
      boot_in     = boot_ff;
      rd_vld_in   = rd_vld_ff;
      rd_first_in = rd_first_ff;
      rd_last_in  = rd_last_ff;
      out_vld_in  = out_vld_ff && rsp_stall;
      out_in      = out_ff;
      if (state_ff == B_IDLE && q_valid) begin
         addr_in     = AW'(q_data.index);
         bit_pos_in  = q_data.bit_pos;
         clr_addr_in = '0;
         k_in        = '0;
      end
      if (state_ff == B_CLEAR) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_last) boot_in = 1'b0;
      end
      if (rd_move && state_ff == B_DATA) rd_vld_in = 1'b0;
      if (issue) begin
         rd_vld_in   = 1'b1;
         rd_first_in = (k_ff == '0);
         rd_last_in  = (k_ff == KW'(NW - 1));
         k_in        = k_ff + KW'(1);
      end
      if (load_direct) begin
         out_vld_in = 1'b1;
         out_in     = direct_word;
      end else if (rd_move && state_ff == B_DATA) begin
         out_vld_in = 1'b1;
         out_in     = stream_word;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      bit_pos_ff  <= bit_pos_in;
      rd_first_ff <= rd_first_in;
      rd_last_ff  <= rd_last_in;
      out_ff      <= out_in;
      k_ff        <= k_in;
   end

   // reset starts a zeroing sweep of the frame store
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_CLEAR;
         boot_ff     <= 1'b1;
         clr_addr_ff <= '0;
         rd_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         boot_ff     <= boot_in;
         clr_addr_ff <= clr_addr_in;
         rd_vld_ff   <= rd_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

endmodule
